/* hdl/wkg_pkg.sv */
`default_nettype none
package wkg_pkg;

   localparam int NUM_LANES = 6;  // a_x, a_y, a_z, b_x, b_y, b_z
   localparam int DIV_STEPS = 31; // one quotient bit per stage

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OUTSIDE   = 2'd1,
      STATUS_ZERO_DIST = 2'd2
   } status_type;

   localparam logic [1:0] CSR_INV_LEN     = 2'd0;
   localparam logic [1:0] CSR_VALUE_SCALE = 2'd1;
   localparam logic [1:0] CSR_GRAD_SCALE  = 2'd2;

   // 1.0 and 2.0 in Q16.16, 2.0 in Q32.32
   localparam logic [18:0] ONE_Q16 = 19'h1_0000;
   localparam logic [17:0] TWO_Q16 = 18'h2_0000;
   localparam logic [62:0] TWO_Q32 = 63'h2_0000_0000;

   // per-request side band travelling with the data
   typedef struct packed {
      logic [30:0] pair_dist;
      logic [29:0] w;
      logic        outside;
      logic        last;
   } meta_type;

   // one lane of the divider: remainder, and a word that shifts the low
   // numerator bits out at the top while quotient bits come in at the bottom
   typedef struct packed {
      logic        neg;
      logic        ovf;
      logic [30:0] rem;
      logic [30:0] word;
   } div_lane_type;

endpackage
`default_nettype wire

/* hdl/wendland_kernel_and_gradient.sv */
// Wendland C2 kernel (2D) and gradient, one particle pair per request.
//
// Request channel (req_*): distance, two signed Q16.16 vectors and a batch
// marker. Accepted on a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): kernel value, six gradient components, status
// and the batch marker. Taken on an edge with rsp_valid high, rsp_stall low.
// CSR port: csr_write_en, csr_index, csr_data; index 3 is ignored. Write only
// while no request is in flight.
//
// Depth: 40 register stages. Throughput: one request per cycle while the
// receiver does not stall. Depth is set by the 31-stage restoring divider
// (one quotient bit per stage, six lanes) after seven multiply stages and a
// divider set-up stage, followed by the output register.
// When the receiver stalls with a response waiting, the whole pipe holds and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipe and loads the registers
// with inv_smoothing_len = 1.0, value_scale = gradient_scale = 655360.
`default_nettype none
module wendland_kernel_and_gradient
   import wkg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [30:0]        req_distance,
   input  wire logic signed [31:0] req_vec_a_x,
   input  wire logic signed [31:0] req_vec_a_y,
   input  wire logic signed [31:0] req_vec_a_z,
   input  wire logic signed [31:0] req_vec_b_x,
   input  wire logic signed [31:0] req_vec_b_y,
   input  wire logic signed [31:0] req_vec_b_z,
   input  wire logic               req_last_pair,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic signed [31:0] rsp_kernel_value,
   output      logic signed [31:0] rsp_grad_a_x,
   output      logic signed [31:0] rsp_grad_a_y,
   output      logic signed [31:0] rsp_grad_a_z,
   output      logic signed [31:0] rsp_grad_b_x,
   output      logic signed [31:0] rsp_grad_b_y,
   output      logic signed [31:0] rsp_grad_b_z,
   output      logic [1:0]         rsp_status,
   output      logic               rsp_last_out,
   input  wire logic               csr_write_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   // ---------------- configuration registers
   logic [31:0] inv_len_ff, value_scale_ff, grad_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_len_ff     <= 32'd65536;
         value_scale_ff <= 32'd655360;
         grad_scale_ff  <= 32'd655360;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_INV_LEN:     inv_len_ff     <= csr_data;
            CSR_VALUE_SCALE: value_scale_ff <= csr_data;
            CSR_GRAD_SCALE:  grad_scale_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- global advance: the whole pipe moves or holds together
   logic rsp_valid_ff;
   logic adv;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---------------- stage A: vector magnitudes, p = distance * inv_len
   logic [31:0] req_vec [NUM_LANES];
   assign req_vec[0] = req_vec_a_x;
   assign req_vec[1] = req_vec_a_y;
   assign req_vec[2] = req_vec_a_z;
   assign req_vec[3] = req_vec_b_x;
   assign req_vec[4] = req_vec_b_y;
   assign req_vec[5] = req_vec_b_z;

   logic        a_v_ff;
   meta_type    a_meta_ff;
   logic [62:0] a_prod_ff;
   logic [31:0] a_vmag_ff [NUM_LANES];
   logic        a_vneg_ff [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (adv) a_v_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_meta_ff.pair_dist <= req_distance;
         a_meta_ff.w         <= '0;
         a_meta_ff.outside   <= 1'b0;
         a_meta_ff.last      <= req_last_pair;
         a_prod_ff           <= 63'(req_distance) * 63'(inv_len_ff);
         for (int i = 0; i < NUM_LANES; i++) begin
            a_vneg_ff[i] <= req_vec[i][31];
            a_vmag_ff[i] <= req_vec[i][31] ? (~req_vec[i] + 32'd1) : req_vec[i];
         end
      end
   end

   // ---------------- stage B: radius test, q, d = 2 - q, d^2
   logic [17:0] b_q_in, b_d_in;
   logic [35:0] b_dsq;
   assign b_q_in = a_prod_ff[33:16];
   assign b_d_in = TWO_Q16 - b_q_in;
   assign b_dsq  = 36'(b_d_in) * 36'(b_d_in);

   logic        b_v_ff;
   meta_type    b_meta_ff;
   logic [17:0] b_q_ff, b_d_ff;
   logic [18:0] b_d2_ff;
   logic [31:0] b_vmag_ff [NUM_LANES];
   logic        b_vneg_ff [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (adv) b_v_ff <= a_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_meta_ff.pair_dist <= a_meta_ff.pair_dist;
         b_meta_ff.w         <= a_meta_ff.w;
         b_meta_ff.outside   <= a_prod_ff > TWO_Q32;
         b_meta_ff.last      <= a_meta_ff.last;
         b_q_ff              <= b_q_in;
         b_d_ff              <= b_d_in;
         b_d2_ff             <= b_dsq[34:16];
         b_vmag_ff           <= a_vmag_ff;
         b_vneg_ff           <= a_vneg_ff;
      end
   end

   // ---------------- stage C: d^3, d^4, 2q + 1
   logic [36:0] c_d3p;
   logic [37:0] c_d4p;
   assign c_d3p = 37'(b_d2_ff) * 37'(b_d_ff);
   assign c_d4p = 38'(b_d2_ff) * 38'(b_d2_ff);

   logic        c_v_ff;
   meta_type    c_meta_ff;
   logic [17:0] c_q_ff;
   logic [18:0] c_t_ff;
   logic [19:0] c_d3_ff;
   logic [20:0] c_d4_ff;
   logic [31:0] c_vmag_ff [NUM_LANES];
   logic        c_vneg_ff [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else if (adv) c_v_ff <= b_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_meta_ff <= b_meta_ff;
         c_q_ff    <= b_q_ff;
         c_t_ff    <= {b_q_ff, 1'b0} + ONE_Q16;
         c_d3_ff   <= c_d3p[35:16];
         c_d4_ff   <= c_d4p[36:16];
         c_vmag_ff <= b_vmag_ff;
         c_vneg_ff <= b_vneg_ff;
      end
   end

   // ---------------- stage D: k = d^4 (2q+1), q d^3
   logic [39:0] d_kp;
   logic [37:0] d_qdp;
   assign d_kp  = 40'(c_d4_ff) * 40'(c_t_ff);
   assign d_qdp = 38'(c_q_ff) * 38'(c_d3_ff);

   logic        d_v_ff;
   meta_type    d_meta_ff;
   logic [21:0] d_k_ff;
   logic [20:0] d_qd_ff;
   logic [31:0] d_vmag_ff [NUM_LANES];
   logic        d_vneg_ff [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else if (adv) d_v_ff <= c_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_meta_ff <= c_meta_ff;
         d_k_ff    <= d_kp[37:16];
         d_qd_ff   <= d_qdp[36:16];
         d_vmag_ff <= c_vmag_ff;
         d_vneg_ff <= c_vneg_ff;
      end
   end

   // ---------------- stage E: W = k * value_scale, m = 10 q d^3
   logic [53:0] e_wp;
   assign e_wp = 54'(d_k_ff) * 54'(value_scale_ff);

   logic        e_v_ff;
   meta_type    e_meta_ff;
   logic [24:0] e_m_ff;
   logic [31:0] e_vmag_ff [NUM_LANES];
   logic        e_vneg_ff [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) e_v_ff <= 1'b0;
      else if (adv) e_v_ff <= d_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_meta_ff.pair_dist <= d_meta_ff.pair_dist;
         e_meta_ff.w         <= d_meta_ff.outside ? '0 : e_wp[53:24];
         e_meta_ff.outside   <= d_meta_ff.outside;
         e_meta_ff.last      <= d_meta_ff.last;
         e_m_ff              <= 25'(d_qd_ff) * 25'd10;
         e_vmag_ff           <= d_vmag_ff;
         e_vneg_ff           <= d_vneg_ff;
      end
   end

   // ---------------- stage F: |P| = m * gradient_scale
   logic [56:0] f_pp;
   assign f_pp = 57'(e_m_ff) * 57'(grad_scale_ff);

   logic        f_v_ff;
   meta_type    f_meta_ff;
   logic [31:0] f_pmag_ff;
   logic [31:0] f_vmag_ff [NUM_LANES];
   logic        f_vneg_ff [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) f_v_ff <= 1'b0;
      else if (adv) f_v_ff <= e_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_meta_ff <= e_meta_ff;
         f_pmag_ff <= f_pp[55:24];
         f_vmag_ff <= e_vmag_ff;
         f_vneg_ff <= e_vneg_ff;
      end
   end

   // ---------------- stage G: numerators |v| * |P|
   logic        g_v_ff;
   meta_type    g_meta_ff;
   logic [63:0] g_num_ff  [NUM_LANES];
   logic        g_vneg_ff [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) g_v_ff <= 1'b0;
      else if (adv) g_v_ff <= f_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_meta_ff <= f_meta_ff;
         g_vneg_ff <= f_vneg_ff;
         for (int i = 0; i < NUM_LANES; i++)
            g_num_ff[i] <= 64'(f_vmag_ff[i]) * 64'(f_pmag_ff);
      end
   end

   // ---------------- divider: set-up stage then one quotient bit per stage
   // a quotient of 2^31 or more saturates either way, so the set-up stage
   // flags it and the remaining quotient fits in 31 bits
   logic         dv_v_ff    [DIV_STEPS+1];
   meta_type     dv_meta_ff [DIV_STEPS+1];
   div_lane_type dv_lane_ff [DIV_STEPS+1][NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) dv_v_ff[0] <= 1'b0;
      else if (adv) dv_v_ff[0] <= g_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_meta_ff[0] <= g_meta_ff;
         for (int i = 0; i < NUM_LANES; i++) begin
            dv_lane_ff[0][i].neg  <= !g_vneg_ff[i]; // gradient opposes v
            dv_lane_ff[0][i].ovf  <= g_num_ff[i][63:31] >= 33'(g_meta_ff.pair_dist);
            dv_lane_ff[0][i].rem  <= g_num_ff[i][61:31];
            dv_lane_ff[0][i].word <= g_num_ff[i][30:0];
         end
      end
   end

   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_div
      logic [31:0] trial [NUM_LANES];
      logic        ge    [NUM_LANES];

      always_comb begin
         for (int i = 0; i < NUM_LANES; i++) begin
            trial[i] = {dv_lane_ff[s-1][i].rem, dv_lane_ff[s-1][i].word[30]};
            ge[i]    = trial[i] >= 32'(dv_meta_ff[s-1].pair_dist);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_v_ff[s] <= 1'b0;
         else if (adv) dv_v_ff[s] <= dv_v_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_meta_ff[s] <= dv_meta_ff[s-1];
            for (int i = 0; i < NUM_LANES; i++) begin
               dv_lane_ff[s][i].neg  <= dv_lane_ff[s-1][i].neg;
               dv_lane_ff[s][i].ovf  <= dv_lane_ff[s-1][i].ovf;
               dv_lane_ff[s][i].rem  <= ge[i] ?
                  31'(trial[i] - 32'(dv_meta_ff[s-1].pair_dist)) : trial[i][30:0];
               dv_lane_ff[s][i].word <= {dv_lane_ff[s-1][i].word[29:0], ge[i]};
            end
         end
      end
   end

   // ---------------- output register: status, sign and saturation
   status_type  st_in;
   logic [31:0] grad_in [NUM_LANES];
   meta_type    fin;
   assign fin = dv_meta_ff[DIV_STEPS];

   always_comb begin
      if (fin.outside)             st_in = STATUS_OUTSIDE;
      else if (fin.pair_dist == '0) st_in = STATUS_ZERO_DIST;
      else                         st_in = STATUS_OK;
      for (int i = 0; i < NUM_LANES; i++) begin
         if (st_in != STATUS_OK)
            grad_in[i] = '0;
         else if (dv_lane_ff[DIV_STEPS][i].ovf)
            grad_in[i] = dv_lane_ff[DIV_STEPS][i].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         else if (dv_lane_ff[DIV_STEPS][i].neg)
            grad_in[i] = 32'd0 - {1'b0, dv_lane_ff[DIV_STEPS][i].word};
         else
            grad_in[i] = {1'b0, dv_lane_ff[DIV_STEPS][i].word};
      end
   end

   logic [31:0] kernel_ff;
   logic [31:0] grad_ff [NUM_LANES];
   status_type  status_ff;
   logic        last_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= dv_v_ff[DIV_STEPS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kernel_ff <= 32'(fin.w);
         grad_ff   <= grad_in;
         status_ff <= st_in;
         last_ff   <= fin.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kernel_value = kernel_ff;
   assign rsp_grad_a_x     = grad_ff[0];
   assign rsp_grad_a_y     = grad_ff[1];
   assign rsp_grad_a_z     = grad_ff[2];
   assign rsp_grad_b_x     = grad_ff[3];
   assign rsp_grad_b_y     = grad_ff[4];
   assign rsp_grad_b_z     = grad_ff[5];
   assign rsp_status       = status_ff;
   assign rsp_last_out     = last_ff;

   // ---------------- checks
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OUTSIDE |-> rsp_kernel_value == '0 &&
      rsp_grad_a_x == '0 && rsp_grad_b_z == '0)
      else $error("outside radius with nonzero output");

   a_zero_dist_grad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ZERO_DIST |-> rsp_grad_a_y == '0 &&
      rsp_grad_b_x == '0)
      else $error("zero distance with nonzero gradient");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kernel_value) &&
      $stable(rsp_status))
      else $error("response lost while stalled");

   a_kernel_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_kernel_value[31])
      else $error("negative kernel value");

endmodule
`default_nettype wire

/* sim/tb_wendland_kernel_and_gradient.sv */
`default_nettype none
module tb_wendland_kernel_and_gradient;
   import wkg_pkg::*;

   // index 3 lands on no register and must be ignored
   localparam logic [1:0] CSR_SPARE = 2'd3;
   // response latency quoted for the pipe, plus margin
   localparam int DRAIN_CYCLES = 48;
   // cycles without any handshake before the run is abandoned
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 240;
   localparam logic [63:0] Q16_ONE = 64'h1_0000;
   localparam logic [63:0] Q32_TWO = 64'h2_0000_0000;

   typedef struct {
      logic [30:0] distance;
      logic [31:0] vec [6];
      logic        last;
   } pair_type;

   typedef struct {
      logic [31:0] kernel;
      logic [31:0] grad [6];
      status_type  status;
      logic        last;
   } kernel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [30:0] req_distance = '0;
   logic signed [31:0] req_vec [6] = '{default: '0};
   logic req_last_pair = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_kernel_value;
   logic signed [31:0] rsp_grad [6];
   logic [1:0] rsp_status;
   logic rsp_last_out;
   logic csr_write_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // local copy of the three registers, tracking what the block holds
   logic [31:0] inv_len_q16;
   logic [31:0] value_scale_q24;
   logic [31:0] grad_scale_q24;

   kernel_result_type pending_results [$];
   int send_idle_pct = 0;   // chance in 100 that the sender idles a cycle
   int recv_stall_pct = 0;  // chance in 100 that the receiver stalls a cycle
   int hold_left = 0;       // long receiver hold-off, counted down below
   int mismatches = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   wendland_kernel_and_gradient u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_distance(req_distance),
      .req_vec_a_x(req_vec[0]), .req_vec_a_y(req_vec[1]), .req_vec_a_z(req_vec[2]),
      .req_vec_b_x(req_vec[3]), .req_vec_b_y(req_vec[4]), .req_vec_b_z(req_vec[5]),
      .req_last_pair(req_last_pair),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kernel_value(rsp_kernel_value),
      .rsp_grad_a_x(rsp_grad[0]), .rsp_grad_a_y(rsp_grad[1]), .rsp_grad_a_z(rsp_grad[2]),
      .rsp_grad_b_x(rsp_grad[3]), .rsp_grad_b_y(rsp_grad[4]), .rsp_grad_b_z(rsp_grad[5]),
      .rsp_status(rsp_status), .rsp_last_out(rsp_last_out),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   // magnitude plus sign to a saturated signed 32-bit word
   function automatic logic [31:0] saturate_s32(bit neg, logic [63:0] mag);
      if (neg) begin
         if (mag >= 64'h8000_0000) return 32'h8000_0000;
         return 32'(64'h1_0000_0000 - mag);
      end
      if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return mag[31:0];
   endfunction

   // kernel value and gradients for one pair under the current registers
   function automatic kernel_result_type wendland_of(pair_type p);
      kernel_result_type r;
      logic [63:0] span, prod, q, d, d2, d3, d4, k, w, m, pmag, vmag;
      bit vneg;
      span = {33'd0, p.distance};
      prod = span * {32'd0, inv_len_q16};
      r.kernel = '0;
      r.grad = '{default: '0};
      r.last = p.last;
      r.status = STATUS_OK;
      if (prod > Q32_TWO) begin
         r.status = STATUS_OUTSIDE;
         return r;
      end
      q = prod >> 16;
      d = 2 * Q16_ONE - q;
      d2 = (d * d) >> 16;
      d3 = (d2 * d) >> 16;
      d4 = (d2 * d2) >> 16;
      k = (d4 * (2 * q + Q16_ONE)) >> 16;
      w = (k * {32'd0, value_scale_q24}) >> 24;
      m = 10 * ((q * d3) >> 16);
      pmag = (m * {32'd0, grad_scale_q24}) >> 24;
      r.kernel = saturate_s32(1'b0, w);
      if (span == 0) begin
         r.status = STATUS_ZERO_DIST;
         return r;
      end
      // prefactor is never positive, so the gradient opposes the vector
      for (int i = 0; i < 6; i++) begin
         vneg = p.vec[i][31];
         vmag = vneg ? 64'h1_0000_0000 - {32'd0, p.vec[i]} : {32'd0, p.vec[i]};
         r.grad[i] = saturate_s32(!vneg, (vmag * pmag) / span);
      end
      return r;
   endfunction

   // offer one request, idling at random first; returns once it is taken
   task automatic send_pair(pair_type p);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_distance <= p.distance;
      for (int i = 0; i < 6; i++) req_vec[i] <= p.vec[i];
      req_last_pair <= p.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(wendland_of(p));
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      end_burst();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_INV_LEN:     inv_len_q16 = val;
         CSR_VALUE_SCALE: value_scale_q24 = val;
         CSR_GRAD_SCALE:  grad_scale_q24 = val;
         default: ;
      endcase
   endtask

   task automatic configure(logic [31:0] inv, logic [31:0] vs, logic [31:0] gs);
      wait_drained();
      write_csr(CSR_INV_LEN, inv);
      write_csr(CSR_VALUE_SCALE, vs);
      write_csr(CSR_GRAD_SCALE, gs);
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_component();
      case ($urandom_range(3))
         0: return $urandom_range(32'h3_FFFF);
         1: return -$urandom_range(32'h3_FFFF);
         default: return $urandom;
      endcase
   endfunction

   // mostly distances that spread q evenly over [0, 2.25], across the kernel radius
   function automatic pair_type random_pair();
      pair_type p;
      logic [63:0] target, span;
      target = {32'd0, $urandom_range(32'h2_4000)} << 16;
      case ($urandom_range(9))
         0: span = {32'd0, $urandom} & 64'h7FFF_FFFF;
         1: span = (inv_len_q16 == 0) ? 64'd0 : Q32_TWO / inv_len_q16;
         2: span = 64'($urandom_range(3));
         default: span = (inv_len_q16 == 0) ? {32'd0, $urandom} & 64'h7FFF_FFFF
                                            : target / inv_len_q16;
      endcase
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      p.distance = span[30:0];
      foreach (p.vec[i]) p.vec[i] = random_component();
      p.last = 1'($urandom_range(1));
      return p;
   endfunction

   task automatic send_random(int count);
      for (int n = 0; n < count; n++) send_pair(random_pair());
   endtask

   // checker: every response against the oldest prediction
   always @(posedge clock) begin
      kernel_result_type exp_r;
      bit bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
         end else begin
            exp_r = pending_results.pop_front();
            bad = (rsp_kernel_value !== exp_r.kernel) || (rsp_status !== exp_r.status)
                  || (rsp_last_out !== exp_r.last);
            for (int i = 0; i < 6; i++) if (rsp_grad[i] !== exp_r.grad[i]) bad = 1;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t: kernel exp %h got %h, status exp %0d got %0d,"
                           , $realtime, exp_r.kernel, rsp_kernel_value, exp_r.status,
                           rsp_status, " last exp %b got %b", exp_r.last, rsp_last_out);
                  for (int i = 0; i < 6; i++)
                     $display("   grad %0d exp %h got %h", i, exp_r.grad[i], rsp_grad[i]);
               end
            end
         end
      end
   end

   // receiver: random stalls, or a long hold-off once asked for
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("tb_wendland_kernel_and_gradient: FAIL");
         $finish;
      end
   end

   // extremes, the radius boundary, zero and unit distance, saturation
   task automatic test_directed();
      pair_type p;
      logic [31:0] edges [6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                 32'h0, 32'h0001_0000, 32'hFFFF_0000};
      logic [30:0] dists [8] = '{31'd0, 31'd1, 31'h1_0000, 31'h2_0000, 31'h2_0001,
                                 31'h1_8000, 31'h7FFF_FFFF, 31'h0_0100};
      for (int n = 0; n < 8; n++) begin
         p.distance = dists[n];
         foreach (p.vec[i]) p.vec[i] = edges[(i + n) % 6];
         p.last = n[0];
         send_pair(p);
      end
      // spare index must leave the registers alone
      wait_drained();
      write_csr(CSR_SPARE, 32'hDEAD_BEEF);
      send_random(8);
      // largest scales push tiny distances into gradient saturation
      configure(32'h1_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int n = 0; n < 8; n++) begin
         p.distance = dists[n];
         foreach (p.vec[i]) p.vec[i] = edges[(i + 2 * n) % 6];
         p.last = ~n[0];
         send_pair(p);
      end
      end_burst();
   endtask

   task automatic test_random_settings(int per_setting);
      configure(32'h1_0000, 32'd655360, 32'd655360);
      send_random(per_setting);
      configure(32'h0, 32'h0, 32'h0);
      send_random(per_setting / 2);
      configure(32'hFFFF_FFFF, $urandom, $urandom);
      send_random(per_setting / 2);
      configure($urandom_range(32'h0010_0000, 32'h0000_1000), $urandom, $urandom);
      send_random(per_setting);
      end_burst();
   endtask

   // block fills while the receiver holds off, then the sender waits it out
   task automatic test_back_pressure();
      configure($urandom_range(32'h0004_0000, 32'h0000_4000), $urandom, $urandom);
      hold_left <= HOLD_CYCLES;
      send_random(90);
      wait_drained();
      send_random(30);
      end_burst();
   endtask

   initial begin
      inv_len_q16 = 32'd65536;
      value_scale_q24 = 32'd655360;
      grad_scale_q24 = 32'd655360;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();

      send_idle_pct = 23;
      recv_stall_pct = 85;
      test_random_settings(110);
      send_idle_pct = 85;
      recv_stall_pct = 23;
      test_random_settings(110);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_settings(110);
      test_back_pressure();

      wait_drained();
      if (mismatches == 0)
         $display("tb_wendland_kernel_and_gradient: PASS");
      else
         $display("tb_wendland_kernel_and_gradient: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

/* wendland_kernel_and_gradient.f */
hdl/wkg_pkg.sv
hdl/wendland_kernel_and_gradient.sv
sim/tb_wendland_kernel_and_gradient.sv
